FILE: src/double_ended_priority_queue_unit_assert.svh
// Assertion macros for the double-ended priority queue unit.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DEPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DEPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DEPQ_ASSERT(label, clk, rst_n, prop, msg)
`define DEPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: src/depq_pkg.sv
// Shared types and constants of the double-ended priority queue unit.
`default_nettype none
package depq_pkg;
  localparam int Capacity   = 128;
  localparam int ValueWidth = 32;
  localparam int IdxW       = $clog2(Capacity);
  localparam int CntW       = $clog2(Capacity + 1);

  localparam logic [1:0] CmdInsert    = 2'd0;
  localparam logic [1:0] CmdRemoveMax = 2'd1;
  localparam logic [1:0] CmdRemoveMin = 2'd2;

  localparam logic [1:0] StDone      = 2'd0;
  localparam logic [1:0] StOverflow  = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [7:0]         count_after;
  } out_item_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StLast = 5'b00100,
    StOut  = 5'b01000,
    StWait = 5'b10000
  } state_e;

  function automatic logic signed [31:0] to_out32(input logic [ValueWidth-1:0] v);
    logic signed [63:0] ext;
    ext = 64'($signed(v));
    return ext[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/depq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module depq_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: src/double_ended_priority_queue_unit.sv
// Top level of the double-ended priority queue unit.
// Values sit unordered in one RAM with a registered read. An insert writes
// at the fill position. A removal scans every held entry through the RAM
// read port, one entry a cycle, then moves the last entry into the freed
// slot. Full-store inserts, empty-store removals and the unused command
// finish without a scan. One item is worked at a time; a finished result
// waits in an output register.
`default_nettype none
`include "double_ended_priority_queue_unit_assert.svh"
module double_ended_priority_queue_unit
  import depq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d, best_idx_q, best_idx_d;
  logic [ValueWidth-1:0] best_q, best_d;
  logic want_max_q, want_max_d;
  out_item_t res_q, res_d;
  logic out_valid_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [ValueWidth-1:0] wdata, rdata;
  logic in_acc, better, next_last;
  logic [CntW-1:0] idx_next;

  depq_ram #(.Width(ValueWidth), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign next_last  = (idx_next >= count_q);
  assign better     = want_max_q ? ($signed(rdata) > $signed(best_q))
                                 : ($signed(rdata) < $signed(best_q));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    want_max_d = want_max_q;
    res_d      = res_q;
    we         = 1'b0;
    waddr      = count_q[IdxW-1:0];
    wdata      = ValueWidth'($unsigned(in_item_i.value_in));
    raddr      = '0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_d.value_out   = '0;
          res_d.status      = StDone;
          res_d.count_after = 8'(count_q);
          state_d           = StOut;
          if (in_item_i.cmd == CmdInsert) begin
            if (count_q >= CntW'(Capacity)) begin
              res_d.status = StOverflow;
            end else begin
              we                = 1'b1;
              count_d           = count_q + CntW'(1);
              res_d.count_after = 8'(count_d);
            end
          end else if (in_item_i.cmd == CmdRemoveMax || in_item_i.cmd == CmdRemoveMin) begin
            if (count_q == '0) begin
              res_d.status = StUnderflow;
            end else begin
              want_max_d = (in_item_i.cmd == CmdRemoveMax);
              idx_d      = '0;
              raddr      = '0;
              state_d    = StScan;
            end
          end
        end
      end
      StScan: begin
        if (idx_q == '0 || better) begin
          best_d     = rdata;
          best_idx_d = idx_q;
        end
        if (next_last) begin
          raddr   = IdxW'(count_q - CntW'(1));
          state_d = StLast;
        end else begin
          idx_d   = idx_next[IdxW-1:0];
          raddr   = idx_next[IdxW-1:0];
        end
      end
      StLast: begin
        we                = 1'b1;
        waddr             = best_idx_q;
        wdata             = rdata;
        count_d           = count_q - CntW'(1);
        res_d.value_out   = to_out32(best_q);
        res_d.status      = StDone;
        res_d.count_after = 8'(count_d);
        state_d           = StOut;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = StIdle;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == StOut || state_q == StWait) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    want_max_q <= want_max_d;
    res_q      <= res_d;
    if ((state_q == StOut || state_q == StWait) && (!out_valid_q || !out_stall_i)) begin
      out_item_o <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `DEPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Capacity),
               "count above capacity")
  `DEPQ_ASSERT(a_last_nonempty, clk_i, rst_ni, (state_q != StLast) || (count_q != '0),
               "removal from empty store")
  `DEPQ_ASSERT_NEXT(a_out_loads, clk_i, rst_ni, state_q == StOut && !out_stall_i,
                    out_valid_q, "result not presented")
endmodule
`default_nettype wire

FILE: tb/sv/double_ended_priority_queue_unit_tb.sv
// Self-checking testbench of the double-ended priority queue unit.
`default_nettype none
module double_ended_priority_queue_unit_tb;
  import depq_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  localparam logic [1:0] CmdUnused = 2'd3;

  double_ended_priority_queue_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Shadow contents of the queue, kept unordered.
  logic signed [31:0] held_vals[$];
  out_item_t          pending_results[$];
  int                 mismatch_cnt;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("double_ended_priority_queue_unit verification failed");
    $finish;
  end

  function automatic out_item_t predict_queue_op(input in_item_t it);
    out_item_t r;
    int        best;
    r = '0;
    r.status = StDone;
    if (it.cmd == CmdInsert) begin
      if (held_vals.size() >= Capacity) r.status = StOverflow;
      else held_vals.push_back(it.value_in);
    end else if (it.cmd == CmdRemoveMax || it.cmd == CmdRemoveMin) begin
      if (held_vals.size() == 0) begin
        r.status = StUnderflow;
      end else begin
        best = 0;
        for (int i = 1; i < held_vals.size(); i++) begin
          if (it.cmd == CmdRemoveMax ? held_vals[i] > held_vals[best]
                                     : held_vals[i] < held_vals[best]) best = i;
        end
        r.value_out = held_vals[best];
        held_vals.delete(best);
      end
    end
    r.count_after = 8'(held_vals.size());
    return r;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    it.cmd = cmd;
    it.value_in = val;
    in_item_i = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_queue_op(it));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item %h", out_item_o);
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (e.value_out !== out_item_o.value_out || e.status !== out_item_o.status ||
            e.count_after !== out_item_o.count_after) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected val %0d st %0d cnt %0d, got val %0d st %0d cnt %0d",
                     e.value_out, e.status, e.count_after, out_item_o.value_out,
                     out_item_o.status, out_item_o.count_after);
        end
      end
    end
  end

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Capacity + 10) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(20)) - 32'd10);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_item(CmdRemoveMax, 32'sd5);
    send_item(CmdRemoveMin, -32'sd1);
    send_item(CmdUnused, 32'sd77);
    send_item(CmdInsert, 32'sh7fffffff);
    send_item(CmdInsert, 32'sh80000000);
    send_item(CmdInsert, 32'sd0);
    send_item(CmdInsert, -32'sd1);
    send_item(CmdInsert, 32'sd0);
    send_item(CmdInsert, 32'sh55555555);
    send_item(CmdInsert, 32'shaaaaaaaa);
    send_item(CmdUnused, 32'sd1);
    send_item(CmdRemoveMax, 32'sd0);
    send_item(CmdRemoveMin, 32'sd0);
    send_item(CmdRemoveMax, 32'sd0);
    send_item(CmdRemoveMin, 32'sd0);
    send_item(CmdRemoveMin, 32'sd0);
    send_item(CmdRemoveMax, 32'sd0);
    send_item(CmdRemoveMax, 32'sd0);
    send_item(CmdRemoveMin, 32'sd0);
    drain_results();
  endtask

  // Fill past capacity, then empty past zero.
  task automatic test_full_and_empty();
    for (int i = 0; i < Capacity + 3; i++) send_item(CmdInsert, rand_value());
    send_item(CmdUnused, 32'sd0);
    for (int i = 0; i < Capacity + 3; i++)
      send_item($urandom_range(1) ? CmdRemoveMax : CmdRemoveMin, rand_value());
    drain_results();
  endtask

  task automatic test_random(input int n, input int ins_pct);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) c = CmdUnused;
      else if ($urandom_range(99) < ins_pct) c = CmdInsert;
      else c = $urandom_range(1) ? CmdRemoveMax : CmdRemoveMin;
      send_item(c, rand_value());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    mismatch_cnt = 0;
    send_idle_pct = 36;
    recv_idle_pct = 61;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_and_empty();
    test_random(400, 70);
    drain_results();
    send_idle_pct = 61;
    recv_idle_pct = 36;
    test_random(400, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300, 60);
    test_random(350, 50);
    drain_results();
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("double_ended_priority_queue_unit verification clean");
    else
      $display("double_ended_priority_queue_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
